@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that is checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/kdeq_pkg.sv @@
// Shared types, constants and codes for the key debounce event queue.
package kdeq_pkg;

   localparam int NumKeysDefault    = 3;
   localparam int QueueDepthDefault = 16;

   localparam int CodeW  = 5;
   localparam int KeysW  = 8;
   localparam int CountW = 8;
   localparam int HoldW  = 16;
   localparam int RepW   = 8;
   localparam int DebW   = 7;
   localparam int CsrW   = 16;

   // Function selector of an input item.
   localparam logic [1:0] FuncScan  = 2'd0;
   localparam logic [1:0] FuncRead  = 2'd1;
   localparam logic [1:0] FuncClear = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CsrDebounceTicks  = 2'd0;
   localparam logic [1:0] CsrLongPressTicks = 2'd1;
   localparam logic [1:0] CsrRepeatTicks    = 2'd2;

   localparam logic [DebW-1:0]   DebounceTicksReset  = 7'd5;
   localparam logic [HoldW-1:0]  LongPressTicksReset = 16'd100;
   localparam logic [RepW-1:0]   RepeatTicksReset    = 8'd0;
   localparam logic [CountW-1:0] DebounceCountReset  = CountW'(5 / 2);

   typedef struct packed {
      logic [DebW-1:0]  debounce_ticks;
      logic [HoldW-1:0] long_press_ticks;
      logic [RepW-1:0]  repeat_ticks;
   } cfg_type;

   // Up to two events that one key raises on one scan tick, in queue order.
   typedef struct packed {
      logic             first_valid;
      logic [CodeW-1:0] first_code;
      logic             second_valid;
      logic [CodeW-1:0] second_code;
   } lane_event_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PUSH = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

@@ src/kdeq_lane.sv @@
// Debounce, hold and repeat logic of one key.
module kdeq_lane #(
   parameter int LANE_ID = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     scan_en,
   input  logic                     pressed,
   input  kdeq_pkg::cfg_type        cfg,
   output logic                     key_down,
   output kdeq_pkg::lane_event_type events
);
   import kdeq_pkg::*;

   localparam logic [CodeW-1:0] CodePress   = CodeW'(3 * LANE_ID + 1);
   localparam logic [CodeW-1:0] CodeRelease = CodeW'(3 * LANE_ID + 2);
   localparam logic [CodeW-1:0] CodeLong    = CodeW'(3 * LANE_ID + 3);

   logic [CountW-1:0] count_ff, count_in;
   logic              down_ff, down_in;
   logic [HoldW-1:0]  hold_ff, hold_in;
   logic [RepW-1:0]   rep_ff, rep_in;
   lane_event_type    events_ff, events_in;

   logic [CountW-1:0] deb_once;
   logic [CountW-1:0] deb_twice;
   logic [HoldW-1:0]  hold_inc;
   logic [RepW-1:0]   rep_inc;

   assign deb_once  = {1'b0, cfg.debounce_ticks};
   assign deb_twice = {cfg.debounce_ticks, 1'b0};
   assign hold_inc  = hold_ff + HoldW'(1);
   assign rep_inc   = rep_ff + RepW'(1);

   always_comb begin
      count_in               = count_ff;
      down_in                = down_ff;
      hold_in                = hold_ff;
      rep_in                 = rep_ff;
      events_in.first_valid  = 1'b0;
      events_in.first_code   = CodePress;
      events_in.second_valid = 1'b0;
      events_in.second_code  = CodePress;
      if (pressed) begin
         if (count_ff < deb_once) begin
            count_in = deb_once;
         end else if (count_ff < deb_twice) begin
            count_in = count_ff + CountW'(1);
         end else begin
            if (!down_ff) begin
               down_in               = 1'b1;
               events_in.first_valid = 1'b1;
            end
            if (cfg.long_press_ticks != '0) begin
               // The hold count saturates; the long event fires only when it is reached.
               if (hold_ff != '1) begin
                  hold_in = hold_inc;
                  if (hold_inc == cfg.long_press_ticks) begin
                     events_in.second_valid = 1'b1;
                     events_in.second_code  = CodeLong;
                  end
               end
            end else if (cfg.repeat_ticks != '0) begin
               rep_in = rep_inc;
               if (rep_inc >= cfg.repeat_ticks) begin
                  rep_in                 = '0;
                  events_in.second_valid = 1'b1;
               end
            end
         end
      end else begin
         if (count_ff > deb_once) begin
            count_in = deb_once;
         end else if (count_ff != '0) begin
            count_in = count_ff - CountW'(1);
         end else if (down_ff) begin
            down_in               = 1'b0;
            events_in.first_valid = 1'b1;
            events_in.first_code  = CodeRelease;
         end
         rep_in  = '0;
         hold_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= DebounceCountReset;
         down_ff   <= 1'b0;
         hold_ff   <= '0;
         rep_ff    <= '0;
         events_ff <= '0;
      end else if (scan_en) begin
         count_ff  <= count_in;
         down_ff   <= down_in;
         hold_ff   <= hold_in;
         rep_ff    <= rep_in;
         events_ff <= events_in;
      end
   end

   assign key_down = down_ff;
   assign events   = events_ff;

endmodule

@@ src/kdeq_queue.sv @@
// Ring queue of event codes without a full check.
module kdeq_queue #(
   parameter int QUEUE_DEPTH = kdeq_pkg::QueueDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  logic [kdeq_pkg::CodeW-1:0] push_code,
   input  logic                       pop,
   input  logic                       clear,
   output logic [kdeq_pkg::CodeW-1:0] pop_code
);
   import kdeq_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

   logic [CodeW-1:0] mem [QUEUE_DEPTH];
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CodeW-1:0] pop_code_ff;
   logic             empty;

   assign empty = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop && !empty) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end else if (clear) begin
         rd_ptr_in = wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem[wr_ptr_ff] <= push_code;
      end
      if (pop) begin
         pop_code_ff <= empty ? '0 : mem[rd_ptr_ff];
      end
   end

   assign pop_code = pop_code_ff;

endmodule

@@ src/key_debounce_event_queue_core.sv @@
// A scan walks its event slots in the push state, since the event queue takes one event slot
// per cycle, then moves to the done state; a read, a clear or an unused function moves
// straight to the done state. The done state loads the output register once it is free or
// its result is taken. One item is in work at a time: no new item is taken before the last
// result is loaded. A finished result waits in the output register while the next item is
// taken. Synchronous active-high reset restores the register defaults, resets the key state,
// empties the queue and drops the result valid; queue contents are not cleared.
module key_debounce_event_queue_core #(
   parameter int NUM_KEYS    = kdeq_pkg::NumKeysDefault,
   parameter int QUEUE_DEPTH = kdeq_pkg::QueueDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [kdeq_pkg::KeysW-1:0] req_key_pressed,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [kdeq_pkg::CodeW-1:0] rsp_key_code,
   output logic [kdeq_pkg::KeysW-1:0] rsp_key_states,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [kdeq_pkg::CsrW-1:0]  csr_wdata
);
   import kdeq_pkg::*;

   localparam int NumSlots = 2 * NUM_KEYS;
   localparam int SlotW    = $clog2(NumSlots);
   localparam logic [SlotW-1:0] SlotLast = SlotW'(NumSlots - 1);

   cfg_type          cfg_ff;
   state_type        state_ff, state_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic             is_read_ff, is_read_in;
   logic             rsp_valid_ff;
   logic [CodeW-1:0] rsp_key_code_ff;
   logic [KeysW-1:0] rsp_key_states_ff;

   logic             accept;
   logic             scan_en;
   logic             pop;
   logic             clear;
   logic             push_valid;
   logic             load_rsp;
   logic [CodeW-1:0] pop_code;

   logic [NUM_KEYS-1:0] key_down_vec;
   lane_event_type      lane_events [NUM_KEYS];
   logic                slot_valid  [NumSlots];
   logic [CodeW-1:0]    slot_code   [NumSlots];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign scan_en   = accept && (req_func == FuncScan);
   assign pop       = accept && (req_func == FuncRead);
   assign clear     = accept && (req_func == FuncClear);

   // Configuration registers; a write leaves all counters alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DebounceTicksReset;
         cfg_ff.long_press_ticks <= LongPressTicksReset;
         cfg_ff.repeat_ticks     <= RepeatTicksReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrDebounceTicks:  cfg_ff.debounce_ticks   <= csr_wdata[DebW-1:0];
            CsrLongPressTicks: cfg_ff.long_press_ticks <= csr_wdata[HoldW-1:0];
            CsrRepeatTicks:    cfg_ff.repeat_ticks     <= csr_wdata[RepW-1:0];
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kdeq_lane #(
         .LANE_ID(k)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .scan_en  (scan_en),
         .pressed  (req_key_pressed[k]),
         .cfg      (cfg_ff),
         .key_down (key_down_vec[k]),
         .events   (lane_events[k])
      );
      assign slot_valid[2*k]   = lane_events[k].first_valid;
      assign slot_code[2*k]    = lane_events[k].first_code;
      assign slot_valid[2*k+1] = lane_events[k].second_valid;
      assign slot_code[2*k+1]  = lane_events[k].second_code;
   end

   // Event slots are walked in key order, one per cycle, and each valid one is pushed.
   assign push_valid = (state_ff == ST_PUSH) && slot_valid[slot_ff];

   kdeq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_code  (slot_code[slot_ff]),
      .pop        (pop),
      .clear      (clear),
      .pop_code   (pop_code)
   );

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      is_read_in = is_read_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               is_read_in = (req_func == FuncRead);
               slot_in    = '0;
               state_in   = (req_func == FuncScan) ? ST_PUSH : ST_DONE;
            end
         end
         ST_PUSH: begin
            if (slot_ff == SlotLast) begin
               state_in = ST_DONE;
            end else begin
               slot_in = slot_ff + SlotW'(1);
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         is_read_ff <= is_read_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_key_code_ff   <= is_read_ff ? pop_code : '0;
         rsp_key_states_ff <= KeysW'(key_down_vec);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code   = rsp_key_code_ff;
   assign rsp_key_states = rsp_key_states_ff;

endmodule

@@ src/kdeq_checker.sv @@
// Port-level checker for the key debounce event queue, bound to the top level.
`include "assert_macros.svh"

module kdeq_checker #(
   parameter int NUM_KEYS = kdeq_pkg::NumKeysDefault
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [kdeq_pkg::CodeW-1:0] rsp_key_code,
   input logic [kdeq_pkg::KeysW-1:0] rsp_key_states
);
   import kdeq_pkg::*;

   localparam logic [CodeW-1:0] CodeMax = CodeW'(3 * NUM_KEYS);

   // A result that is not taken keeps its code and key states.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code) && $stable(rsp_key_states), "result changed while stalled")

   // Codes beyond the last key's long-press code cannot be queued.
   `ASSERT_CLK(a_code_range, clock, reset, rsp_valid |-> rsp_key_code <= CodeMax, "event code out of range")

   // Keys that are not fitted never show as pressed.
   `ASSERT_CLK(a_states_keys, clock, reset, rsp_valid |-> (rsp_key_states >> NUM_KEYS) == '0, "state bit set for an absent key")

   // Reset drops any pending result.
   `ASSERT_ALWAYS(a_reset_drop, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind key_debounce_event_queue_core kdeq_checker #(
   .NUM_KEYS(NUM_KEYS)
) u_kdeq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_key_code   (rsp_key_code),
   .rsp_key_states (rsp_key_states)
);

@@ tb/key_debounce_event_queue_core_test.sv @@
// Self-checking testbench for the key debounce event queue core.
`timescale 1ns / 1ps

module key_debounce_event_queue_core_test;
   import kdeq_pkg::*;

   localparam int KEYS        = NumKeysDefault;
   localparam int SpareW      = KeysW - KEYS;
   localparam int QuietLimit  = 2000;
   localparam int SettleTicks = 16;

   localparam logic [1:0] FuncUnused = 2'd3;
   localparam logic [1:0] CsrUnused  = 2'd3;

   typedef struct {
      logic [1:0]       func;
      logic [KeysW-1:0] keys;
   } key_request_type;

   typedef struct {
      logic [CodeW-1:0] code;
      logic [KeysW-1:0] states;
   } key_report_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_func = FuncScan;
   logic [KeysW-1:0] req_key_pressed = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [CodeW-1:0] rsp_key_code;
   logic [KeysW-1:0] rsp_key_states;
   logic             csr_wr_en = 1'b0;
   logic [1:0]       csr_index = CsrDebounceTicks;
   logic [CsrW-1:0]  csr_wdata = '0;

   key_debounce_event_queue_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_key_pressed(req_key_pressed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_code   (rsp_key_code),
      .rsp_key_states (rsp_key_states),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: settings, per-key debounce state and the event ring.
   logic [DebW-1:0]   cfg_debounce;
   logic [HoldW-1:0]  cfg_long_press;
   logic [RepW-1:0]   cfg_repeat;
   logic [CountW-1:0] deb_count  [KEYS];
   logic              key_down   [KEYS];
   logic [HoldW-1:0]  hold_count [KEYS];
   logic [RepW-1:0]   rep_count  [KEYS];
   logic [CodeW-1:0]  event_ring [16];
   logic [3:0]        ring_rd;
   logic [3:0]        ring_wr;

   key_request_type key_requests [$];
   key_report_type  expected_reports [$];
   key_request_type next_request;
   key_report_type  oldest_report;

   bit idle_enabled = 1'b1;
   int send_gap;
   int stall_left;
   int quiet_cycles;
   int errors;
   int n_scans, n_reads, n_codes, n_clears, n_settings;

   function automatic void reset_key_model();
      cfg_debounce   = DebounceTicksReset;
      cfg_long_press = LongPressTicksReset;
      cfg_repeat     = RepeatTicksReset;
      for (int k = 0; k < KEYS; k++) begin
         deb_count[k]  = CountW'(DebounceTicksReset / 2);
         key_down[k]   = 1'b0;
         hold_count[k] = '0;
         rep_count[k]  = '0;
      end
      ring_rd = '0;
      ring_wr = '0;
   endfunction

   // No full check: a write that catches up with the read side empties the ring.
   function automatic void push_key_event(logic [CodeW-1:0] code);
      event_ring[ring_wr] = code;
      ring_wr++;
   endfunction

   function automatic void debounce_key(int k, logic pressed);
      logic [CodeW-1:0] base;
      base = CodeW'(3 * k);
      if (pressed) begin
         if (int'(deb_count[k]) < int'(cfg_debounce)) begin
            deb_count[k] = CountW'(cfg_debounce);
         end else if (int'(deb_count[k]) < 2 * int'(cfg_debounce)) begin
            deb_count[k]++;
         end else begin
            if (!key_down[k]) begin
               key_down[k] = 1'b1;
               push_key_event(base + CodeW'(1));
            end
            if (cfg_long_press != '0) begin
               if (hold_count[k] != '1) begin
                  hold_count[k]++;
                  if (hold_count[k] == cfg_long_press)
                     push_key_event(base + CodeW'(3));
               end
            end else if (cfg_repeat != '0) begin
               rep_count[k]++;
               if (rep_count[k] >= cfg_repeat) begin
                  rep_count[k] = '0;
                  push_key_event(base + CodeW'(1));
               end
            end
         end
      end else begin
         if (int'(deb_count[k]) > int'(cfg_debounce)) begin
            deb_count[k] = CountW'(cfg_debounce);
         end else if (deb_count[k] != '0) begin
            deb_count[k]--;
         end else if (key_down[k]) begin
            key_down[k] = 1'b0;
            push_key_event(base + CodeW'(2));
         end
         rep_count[k]  = '0;
         hold_count[k] = '0;
      end
   endfunction

   function automatic void predict_key_report(logic [1:0] func, logic [KeysW-1:0] keys);
      key_report_type report;
      report.code = '0;
      case (func)
         FuncScan: begin
            n_scans++;
            for (int k = 0; k < KEYS; k++)
               debounce_key(k, keys[k]);
         end
         FuncRead: begin
            n_reads++;
            if (ring_rd != ring_wr) begin
               report.code = event_ring[ring_rd];
               ring_rd++;
               n_codes++;
            end
         end
         FuncClear: begin
            n_clears++;
            ring_rd = ring_wr;
         end
         default: ;
      endcase
      report.states = '0;
      for (int k = 0; k < KEYS; k++)
         report.states[k] = key_down[k];
      expected_reports.push_back(report);
   endfunction

   // Request side: the predictor runs on every accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            predict_key_report(req_func, req_key_pressed);
         if (req_valid && !req_ready) begin
            // The offered item stays put until it is taken.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (key_requests.size() > 0 && idle_enabled &&
                      $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 15);
            req_valid <= 1'b0;
         end else if (key_requests.size() > 0) begin
            next_request = key_requests.pop_front();
            req_valid       <= 1'b1;
            req_func        <= next_request.func;
            req_key_pressed <= next_request.keys;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: compare each transfer with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual code %0d states %b",
                        $time, rsp_key_code, rsp_key_states);
            end else begin
               oldest_report = expected_reports.pop_front();
               if (rsp_key_code !== oldest_report.code) begin
                  errors++;
                  $display("%0t: key_code mismatch: expected %0d, actual %0d",
                           $time, oldest_report.code, rsp_key_code);
               end
               if (rsp_key_states !== oldest_report.states) begin
                  errors++;
                  $display("%0t: key_states mismatch: expected %b, actual %b",
                           $time, oldest_report.states, rsp_key_states);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
         $display("** key_debounce_event_queue_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_request(logic [1:0] func, logic [KeysW-1:0] keys);
      key_request_type req;
      req.func = func;
      req.keys = keys;
      key_requests.push_back(req);
   endtask

   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (key_requests.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SettleTicks) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [CsrW-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CsrDebounceTicks:  cfg_debounce   = data[DebW-1:0];
         CsrLongPressTicks: cfg_long_press = data[HoldW-1:0];
         CsrRepeatTicks:    cfg_repeat     = data[RepW-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Upper data bits are filled with noise, since only the register width counts.
   task automatic apply_settings(int debounce, int long_press, int repeat_period);
      logic [CsrW-1:0] data;
      wait_until_drained();
      data = CsrW'($urandom);
      data[DebW-1:0] = DebW'(debounce);
      write_csr(CsrDebounceTicks, data);
      write_csr(CsrLongPressTicks, HoldW'(long_press));
      data = CsrW'($urandom);
      data[RepW-1:0] = RepW'(repeat_period);
      write_csr(CsrRepeatTicks, data);
      write_csr(CsrUnused, CsrW'($urandom));
      n_settings++;
   endtask

   // Runs of steady key levels with some bounce, mixed with reads, clears and unused functions;
   // a run without reads can let the ring overflow, after which a burst of reads drains it.
   task automatic queue_key_session(int n_items, int max_run, int read_pct);
      logic [KeysW-1:0] level;
      logic [KeysW-1:0] keys;
      int               run;
      int               sent;
      int               flip;
      bit               no_reads;
      sent = 0;
      while (sent < n_items) begin
         run      = $urandom_range(1, max_run);
         level    = KeysW'($urandom);
         no_reads = ($urandom_range(0, 7) == 0);
         repeat (run) begin
            keys = level;
            if ($urandom_range(0, 9) == 0) begin
               flip = $urandom_range(0, KEYS - 1);
               keys[flip] = ~keys[flip];
            end
            keys[KeysW-1:KEYS] = SpareW'($urandom);
            add_request(FuncScan, keys);
            sent++;
            if (!no_reads && $urandom_range(0, 99) < read_pct) begin
               add_request(FuncRead, KeysW'($urandom));
               sent++;
            end
            if ($urandom_range(0, 99) == 0) begin
               add_request(FuncClear, KeysW'($urandom));
               sent++;
            end
            if ($urandom_range(0, 149) == 0) begin
               add_request(FuncUnused, KeysW'($urandom));
               sent++;
            end
         end
         if (no_reads) begin
            repeat (18) add_request(FuncRead, KeysW'($urandom));
            sent += 18;
         end
      end
   endtask

   initial begin
      reset_key_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty ring, unused function and ignored key bits first.
      add_request(FuncRead, 8'h00);
      add_request(FuncUnused, 8'hFF);
      add_request(FuncClear, 8'h00);
      add_request(FuncScan, 8'hF8);
      repeat (7) add_request(FuncScan, 8'hFF);
      repeat (4) add_request(FuncRead, 8'hFF);
      repeat (7) add_request(FuncScan, 8'h00);
      add_request(FuncClear, 8'hFF);
      add_request(FuncRead, 8'h00);
      queue_key_session(300, 40, 25);

      apply_settings(1, 3, 0);
      queue_key_session(250, 20, 30);
      apply_settings(0, 0, 1);
      queue_key_session(250, 12, 30);
      apply_settings(3, 0, 255);
      queue_key_session(300, 300, 10);
      apply_settings(127, 65535, 7);
      queue_key_session(500, 320, 10);

      apply_settings(1, 1, 4);
      idle_enabled = 1'b0;
      queue_key_session(300, 16, 30);

      wait_until_drained();
      $display("Run covered %0d scan ticks, %0d reads (%0d returned a code) and %0d clears,",
               n_scans, n_reads, n_codes, n_clears);
      $display("over the reset settings and %0d written ones, with ring overflow.",
               n_settings);
      if (errors == 0)
         $display("** key_debounce_event_queue_core: PASSED **");
      else
         $display("** key_debounce_event_queue_core: FAILED **");
      $finish;
   end

endmodule
